// ===== rtl/dpf_pkg.sv =====
// Package with the constants, types and helper functions of the deduplicating packet FIFO.
`timescale 1ns / 1ps
package dpf_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int LIMIT_W  = 6;
  localparam int CNT_W    = 6;
  localparam int SRC_W    = 16;
  localparam int DST_W    = 16;
  localparam int TS_W     = 32;
  localparam int ENTRY_W  = SRC_W + DST_W + TS_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_FORWARD = 2'd1,
    REQ_COUNT   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } dpf_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic last_issue;
  } dpf_stat_t;

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (32'(idx) == 32'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = idx + IDX_W'(1);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    logic [IDX_W-1:0] r;
    sum = {1'b0, base} + {1'b0, ofs};
    if (32'(sum) >= 32'(CAPACITY)) begin
      r = IDX_W'(32'(sum) - 32'(CAPACITY));
    end else begin
      r = sum[IDX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dpf_ctrl.sv =====
// Controller state machine that sequences the scan, fetch and finish steps of one request.
`timescale 1ns / 1ps
module dpf_ctrl
  import dpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [1:0] req_type,
  input  dpf_stat_t stat,
  output dpf_cmd_t  cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (stat.occ_zero) begin
            state_next = ST_FINISH;
          end else if (req_type inside {REQ_ADD, REQ_COUNT}) begin
            state_next = ST_SCAN;
          end else if (req_type == REQ_FORWARD) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (stat.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FETCH:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN:   cmd.issue = 1'b1;
      ST_FETCH:  cmd.issue = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/dpf_datapath.sv =====
// Datapath with the entry memory, FIFO pointers, scan compare logic and result registers.
`timescale 1ns / 1ps
module dpf_datapath
  import dpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dpf_cmd_t           cmd,
  output dpf_stat_t          stat,
  input  logic [1:0]         req_type,
  input  logic [SRC_W-1:0]   source,
  input  logic [DST_W-1:0]   destination,
  input  logic [TS_W-1:0]    timestamp,
  input  logic [TS_W-1:0]    start_time,
  input  logic [TS_W-1:0]    end_time,
  input  logic               mem_limit_we,
  input  logic [LIMIT_W-1:0] mem_limit_wdata,
  output logic               done,
  output logic               added,
  output logic               packet_valid,
  output logic [SRC_W-1:0]   out_source,
  output logic [DST_W-1:0]   out_destination,
  output logic [TS_W-1:0]    out_timestamp,
  output logic [CNT_W-1:0]   match_count
);

  logic [ENTRY_W-1:0] mem [CAPACITY];

  logic [1:0]         req;
  logic [SRC_W-1:0]   src;
  logic [DST_W-1:0]   dst;
  logic [TS_W-1:0]    ts;
  logic [TS_W-1:0]    lo;
  logic [TS_W-1:0]    hi;
  logic [IDX_W-1:0]   k;
  logic               rd_pending;
  logic [ENTRY_W-1:0] rd_data;
  logic               dup;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   tail;
  logic [OCC_W-1:0]   occ;
  logic [LIMIT_W-1:0] mem_limit;

  logic [IDX_W-1:0]   rd_addr;
  logic [SRC_W-1:0]   e_src;
  logic [DST_W-1:0]   e_dst;
  logic [TS_W-1:0]    e_ts;
  logic               hit_dup;
  logic               hit_cnt;
  logic [OCC_W-1:0]   lim;
  logic               do_write;

  assign rd_addr = slot_add(head, k);
  assign e_src   = rd_data[ENTRY_W-1 -: SRC_W];
  assign e_dst   = rd_data[TS_W +: DST_W];
  assign e_ts    = rd_data[TS_W-1:0];
  assign hit_dup = (e_src == src) && (e_dst == dst) && (e_ts == ts);
  assign hit_cnt = (e_dst == dst) && (e_ts >= lo) && (e_ts <= hi) && (cnt != CNT_MAX);

  always_comb begin
    if (mem_limit == '0) begin
      lim = OCC_W'(1);
    end else if (32'(mem_limit) > 32'(CAPACITY)) begin
      lim = OCC_W'(CAPACITY);
    end else begin
      lim = OCC_W'(mem_limit);
    end
  end

  assign do_write = cmd.finish && (req == REQ_ADD) && !dup;

  assign stat.occ_zero   = (occ == '0);
  assign stat.last_issue = (OCC_W'(k) == occ - OCC_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
    if (do_write) begin
      mem[tail] <= {src, dst, ts};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type;
      src <= source;
      dst <= destination;
      ts  <= timestamp;
      lo  <= start_time;
      hi  <= end_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      occ        <= '0;
      mem_limit  <= LIMIT_RESET;
      rd_pending <= 1'b0;
      done       <= 1'b0;
      k          <= '0;
      dup        <= 1'b0;
      cnt        <= '0;
    end else begin
      done       <= cmd.finish;
      rd_pending <= cmd.issue;
      if (mem_limit_we) begin
        mem_limit <= mem_limit_wdata;
      end
      if (cmd.load) begin
        k   <= '0;
        dup <= 1'b0;
        cnt <= '0;
      end else begin
        if (cmd.issue) begin
          k <= k + IDX_W'(1);
        end
        if (rd_pending) begin
          if (hit_dup) begin
            dup <= 1'b1;
          end
          if (hit_cnt) begin
            cnt <= cnt + CNT_W'(1);
          end
        end
      end
      if (do_write) begin
        tail <= slot_inc(tail);
        if (occ >= lim) begin
          head <= slot_inc(head);
        end else begin
          occ <= occ + OCC_W'(1);
        end
      end else if (cmd.finish && (req == REQ_FORWARD) && (occ != '0)) begin
        head <= slot_inc(head);
        occ  <= occ - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      added           <= do_write;
      packet_valid    <= 1'b0;
      out_source      <= '0;
      out_destination <= '0;
      out_timestamp   <= '0;
      match_count     <= '0;
      case (req)
        REQ_FORWARD: begin
          if (occ != '0) begin
            packet_valid    <= 1'b1;
            out_source      <= e_src;
            out_destination <= e_dst;
            out_timestamp   <= e_ts;
          end
        end
        REQ_COUNT: match_count <= cnt;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dedup_packet_fifo_with_range_count.sv =====
// Top level of the packet FIFO with duplicate filter and per-destination range count.
//
//   Channel   Handshake            Payload
//   request   start / busy         req_type, source, destination, timestamp,
//                                  start_time, end_time
//   result    done (one cycle)     added, packet_valid, out_source,
//                                  out_destination, out_timestamp, match_count
//   config    mem_limit_we         mem_limit_wdata
//
// An add or a count scans the stored entries through the single memory read port, one
// entry per cycle, then drain and finish; an empty buffer goes directly to finish.
// A forward uses fetch and finish; an unused code or empty buffer skips to finish.
// Reset is synchronous and empties the buffer; mem_limit returns to 32.
// The result beat cannot be stalled; busy is low again in the cycle done is high.
`timescale 1ns / 1ps
module dedup_packet_fifo_with_range_count
  import dpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [SRC_W-1:0]   source,
  input  logic [DST_W-1:0]   destination,
  input  logic [TS_W-1:0]    timestamp,
  input  logic [TS_W-1:0]    start_time,
  input  logic [TS_W-1:0]    end_time,
  input  logic               mem_limit_we,
  input  logic [LIMIT_W-1:0] mem_limit_wdata,
  output logic               done,
  output logic               added,
  output logic               packet_valid,
  output logic [SRC_W-1:0]   out_source,
  output logic [DST_W-1:0]   out_destination,
  output logic [TS_W-1:0]    out_timestamp,
  output logic [CNT_W-1:0]   match_count
);

  dpf_cmd_t  cmd;
  dpf_stat_t stat;

  dpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  dpf_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_type        (req_type),
    .source          (source),
    .destination     (destination),
    .timestamp       (timestamp),
    .start_time      (start_time),
    .end_time        (end_time),
    .mem_limit_we    (mem_limit_we),
    .mem_limit_wdata (mem_limit_wdata),
    .done            (done),
    .added           (added),
    .packet_valid    (packet_valid),
    .out_source      (out_source),
    .out_destination (out_destination),
    .out_timestamp   (out_timestamp),
    .match_count     (match_count)
  );

endmodule

// ===== rtl/dpf_checker.sv =====
// Port-level checker for the packet FIFO and the bind that attaches it to the top level.
`timescale 1ns / 1ps
module dpf_checker
  import dpf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             added,
  input logic             packet_valid,
  input logic [CNT_W-1:0] match_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted request did not raise busy.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("Result beat without a request in flight.");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result beat lasted more than one cycle.");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(added && packet_valid))
    else $error("Result flags both an add and a forward.");

  a_fwd_no_count: assert property (@(posedge clk) disable iff (rst)
    (done && (added || packet_valid)) |-> (match_count == '0))
    else $error("Count set on an add or forward result.");

endmodule

bind dedup_packet_fifo_with_range_count dpf_checker u_dpf_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .added        (added),
  .packet_valid (packet_valid),
  .match_count  (match_count)
);
